@@ hw/rtl/bsr_pkg.sv @@
package bsr_pkg;

  // Ring size; a power of two so the slot is the low bits of the position.
  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int POS_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int FUNC_W   = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_MARK,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] value;
    logic              eof;
    logic [CNT_W-1:0]  read_count;
  } cmd_t;

endpackage

@@ hw/rtl/bsr_ram.sv @@
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/bsr_front.sv @@
module bsr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [bsr_pkg::FUNC_W-1:0] func,
  input  logic [bsr_pkg::POS_W-1:0]  pos,
  input  logic [bsr_pkg::BYTE_W-1:0] value,
  input  logic                     eof,
  input  logic [bsr_pkg::CNT_W-1:0]  read_count,
  output logic                     push,
  output bsr_pkg::cmd_t            push_cmd,
  input  logic                     q_full
);
  import bsr_pkg::*;

  logic f_valid;
  cmd_t f_cmd;
  op_t  op_dec;
  logic accept;

  always_comb begin
    unique case (func)
      FUNC_BYTE: op_dec = OP_BYTE;
      FUNC_MARK: op_dec = OP_MARK;
      FUNC_READ: op_dec = OP_READ;
      default:   op_dec = OP_NOP;
    endcase
  end

  assign push     = f_valid && !q_full;
  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push_cmd = f_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept || (f_valid && !push);
    end
    if (accept) begin
      f_cmd.op         <= op_dec;
      f_cmd.pos        <= pos;
      f_cmd.value      <= value;
      f_cmd.eof        <= eof;
      f_cmd.read_count <= read_count;
    end
  end

endmodule

@@ hw/rtl/bsr_cmd_queue.sv @@
module bsr_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bsr_pkg::cmd_t push_cmd,
  output logic          q_full,
  output logic          q_valid,
  output bsr_pkg::cmd_t q_cmd,
  input  logic          pop
);
  import bsr_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/bsr_back.sv @@
module bsr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  bsr_pkg::cmd_t              q_cmd,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       has_byte,
  output logic [bsr_pkg::BYTE_W-1:0] out_byte,
  output logic                       stream_ended,
  output logic [bsr_pkg::CNT_W-1:0]  unassembled_count,
  output logic                       last
);
  import bsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN,
    S_FIN,
    S_STAT,
    S_RD,
    S_LD
  } state_t;

  state_t              state;
  cmd_t                cmd;
  logic [CAPACITY-1:0] ring_valid;
  logic [POS_W-1:0]    next_expected;
  logic [CNT_W-1:0]    unread;
  logic                end_known;
  logic [POS_W-1:0]    end_position;
  logic [CNT_W-1:0]    held_count;
  logic                ended;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    idx;
  logic                pend;
  logic [SLOT_W-1:0]   pend_idx;

  logic [POS_W-1:0]  ahead;
  logic [CNT_W-1:0]  win_sum;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] head;
  logic              store_ok;
  logic              drain_step;
  logic [CNT_W-1:0]  rc_sat;
  logic              out_free;
  logic [BYTE_W-1:0] ring_rd;
  logic [BYTE_W-1:0] obuf_rd;

  assign pop        = (state == S_IDLE) && q_valid;
  assign slot       = cmd.pos[SLOT_W-1:0];
  assign head       = next_expected[SLOT_W-1:0];
  assign ahead      = cmd.pos - next_expected;
  assign win_sum    = {1'b0, ahead[SLOT_W-1:0]} + unread;
  assign store_ok   = (cmd.op == OP_BYTE) && !ended && (cmd.pos >= next_expected) &&
                      (ahead[POS_W-1:SLOT_W] == '0) &&
                      (win_sum <= CNT_W'(CAPACITY - 1)) && !ring_valid[slot];
  assign drain_step = (state == S_DRAIN) && ring_valid[head];
  assign rc_sat     = (cmd.read_count > unread) ? unread : cmd.read_count;
  assign out_free   = !out_valid || !out_stall;

  bsr_ram #(.WIDTH(BYTE_W), .DEPTH(CAPACITY)) u_ring (
    .clk     (clk),
    .wr_en   ((state == S_EXEC) && store_ok),
    .wr_addr (slot),
    .wr_data (cmd.value),
    .rd_en   (drain_step),
    .rd_addr (head),
    .rd_data (ring_rd)
  );

  // Holds the bytes of one drain until the final status is known.
  bsr_ram #(.WIDTH(BYTE_W), .DEPTH(CAPACITY)) u_obuf (
    .clk     (clk),
    .wr_en   (pend),
    .wr_addr (pend_idx),
    .wr_data (ring_rd),
    .rd_en   (state == S_RD),
    .rd_addr (idx[SLOT_W-1:0]),
    .rd_data (obuf_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ring_valid    <= '0;
      next_expected <= '0;
      unread        <= '0;
      end_known     <= 1'b0;
      end_position  <= '0;
      held_count    <= '0;
      ended         <= 1'b0;
      n             <= '0;
      idx           <= '0;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      pend     <= drain_step;
      pend_idx <= n[SLOT_W-1:0];
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          n <= '0;
          unique case (cmd.op) inside
            OP_READ: begin
              unread <= unread - rc_sat;
              state  <= S_STAT;
            end
            OP_BYTE, OP_MARK: begin
              if (ended) begin
                state <= S_STAT;
              end else begin
                if (cmd.eof) begin
                  end_known    <= 1'b1;
                  end_position <= (cmd.op == OP_BYTE) ? cmd.pos + 1'b1 : cmd.pos;
                end
                if (store_ok) begin
                  ring_valid[slot] <= 1'b1;
                  held_count       <= held_count + 1'b1;
                end
                state <= S_DRAIN;
              end
            end
            default: begin
              state <= S_STAT;
            end
          endcase
        end
        S_DRAIN: begin
          if (drain_step) begin
            ring_valid[head] <= 1'b0;
            next_expected    <= next_expected + 1'b1;
            held_count       <= held_count - 1'b1;
            unread           <= unread + 1'b1;
            n                <= n + 1'b1;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (end_known && (next_expected >= end_position)) begin
            ended      <= 1'b1;
            ring_valid <= '0;
            held_count <= '0;
          end
          idx   <= '0;
          state <= (n == '0) ? S_STAT : S_RD;
        end
        S_STAT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            has_byte          <= 1'b0;
            out_byte          <= '0;
            stream_ended      <= ended;
            unassembled_count <= held_count;
            last              <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            has_byte          <= 1'b1;
            out_byte          <= obuf_rd;
            stream_ended      <= ended;
            unassembled_count <= held_count;
            last              <= (idx == n - 1'b1);
            idx               <= idx + 1'b1;
            state             <= (idx == n - 1'b1) ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/byte_stream_reassembler_top.sv @@
// Channel   Handshake            Payload
// input     in_valid / in_stall  func, pos, value, eof, read_count
// output    out_valid / out_stall has_byte, out_byte, stream_ended,
//                                unassembled_count, last
//
// A reader count, an ignored request or a segment after end of stream passes idle,
// execute and status in the back part; other segments pass idle, execute, drain
// (one step per ring slot walked: single read port of the ring) and finish, then
// status if none is released, else a read and load per staged byte (registered read).
// Reset (rst, synchronous) clears all valid bits and counters at once; there
// is no clearing pass.
// A stall on the output holds the result register and the back part; the
// front keeps taking requests until its stage and the two-entry queue fill.
module byte_stream_reassembler_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bsr_pkg::FUNC_W-1:0] func,
  input  logic [bsr_pkg::POS_W-1:0]  pos,
  input  logic [bsr_pkg::BYTE_W-1:0] value,
  input  logic                       eof,
  input  logic [bsr_pkg::CNT_W-1:0]  read_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       has_byte,
  output logic [bsr_pkg::BYTE_W-1:0] out_byte,
  output logic                       stream_ended,
  output logic [bsr_pkg::CNT_W-1:0]  unassembled_count,
  output logic                       last
);
  import bsr_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // Decode the request code and hold one request.
  bsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .pos        (pos),
    .value      (value),
    .eof        (eof),
    .read_count (read_count),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  // Decouple the front from the drain and playout.
  bsr_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  // Store, drain in order, detect end of stream, and emit results.
  bsr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .has_byte          (has_byte),
    .out_byte          (out_byte),
    .stream_ended      (stream_ended),
    .unassembled_count (unassembled_count),
    .last              (last)
  );

endmodule

@@ hw/rtl/bsr_checker.sv @@
module bsr_props (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       has_byte,
  input logic [bsr_pkg::BYTE_W-1:0] out_byte,
  input logic                       stream_ended,
  input logic [bsr_pkg::CNT_W-1:0]  unassembled_count,
  input logic                       last
);
  import bsr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last && (out_byte == '0))
    else $error("status result not final or carries data");

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_ended |-> (unassembled_count == '0))
    else $error("bytes held after end of stream");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (unassembled_count <= CNT_W'(CAPACITY)))
    else $error("held count above capacity");

endmodule

bind byte_stream_reassembler_top bsr_props u_bsr_props (.*);
